// ----- design/cps_pkg.sv -----
// Package for the companion power sequencer: phase codes, register indexes,
// register reset values and the result record type.
// No dependencies; used by companion_power_sequencer_unit.
package cps_pkg;

    // Width of every configuration register.
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;

    // Sequencer phases, as reported on the phase output.
    typedef enum logic [2:0] {
        PH_BOOT     = 3'd0,
        PH_WAIT     = 3'd1,
        PH_RUNNING  = 3'd2,
        PH_SHUTDOWN = 3'd3,
        PH_OFF      = 3'd4,
        PH_FORCED   = 3'd5
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOOT_DELAY     = 3'd0,
        REG_READY_TIMEOUT  = 3'd1,
        REG_LINK_TIMEOUT   = 3'd2,
        REG_SHUTDOWN_REPEAT = 3'd3,
        REG_DEBOUNCE       = 3'd4,
        REG_LONG_PRESS     = 3'd5
    } t_reg_idx;

    // Register values after reset, in milliseconds.
    localparam logic [CFG_W-1:0] BOOT_DELAY_RST      = 16'd2000;
    localparam logic [CFG_W-1:0] READY_TIMEOUT_RST   = 16'd10000;
    localparam logic [CFG_W-1:0] LINK_TIMEOUT_RST    = 16'd2000;
    localparam logic [CFG_W-1:0] SHUTDOWN_REPEAT_RST = 16'd100;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST        = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST      = 16'd3000;

    // One result record, as held in the output register.
    typedef struct packed {
        logic   power_enable;
        logic   failsafe;
        t_phase phase;
        logic   link_up;
        logic   shutdown_pending;
        logic   send_shutdown;
        logic   offline_shown;
        logic   shutdown_started;
        logic   forced_off_event;
    } t_result;

endpackage

// ----- design/companion_power_sequencer_unit.sv -----
// Companion power sequencer top level: tick register, sequencer step logic,
// state and result register. Depends on cps_pkg.
//
// Each request is one millisecond tick with the raw button level and the
// companion status pins. The block debounces the button, sequences the
// companion supply through boot delay, wait ready, running, shutdown
// requested, powered off and forced off, and returns one result per tick.
// A tick passes through the input register and then the result register,
// and a new tick is taken every cycle as long as the result side keeps up.
// Configuration registers must only be written while no tick is in flight.
// Both off phases hold until reset, except that a long press in powered off
// moves to forced off; all timers saturate at 2^TIMER_WIDTH - 1.
module companion_power_sequencer_unit #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port
    input  logic                       i_cfg_wr_en,
    input  logic [cps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cps_pkg::CFG_W-1:0]  i_cfg_data,
    // Tick request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_button_raw,
    input  logic                       i_poweroff_ok,
    input  logic                       i_rx_frame,
    input  logic                       i_tx_ready,
    // Result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_power_enable,
    output logic                       o_failsafe,
    output logic [2:0]                 o_phase,
    output logic                       o_link_up,
    output logic                       o_shutdown_pending,
    output logic                       o_send_shutdown,
    output logic                       o_offline_shown,
    output logic                       o_shutdown_started,
    output logic                       o_forced_off_event
);
    import cps_pkg::*;

    // Compare width wide enough for both timers and registers.
    localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    // Configuration registers.
    logic [CFG_W-1:0] r_boot_delay, r_ready_timeout, r_link_timeout;
    logic [CFG_W-1:0] r_shutdown_repeat, r_debounce, r_long_press;

    // Input register.
    logic r_in_valid;
    logic r_button_raw, r_poweroff_ok, r_rx_frame, r_tx_ready;

    // Sequencer state.
    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_phase_age, n_phase_age;
    logic [TIMER_WIDTH-1:0] r_repeat_age, n_repeat_age;
    logic [TIMER_WIDTH-1:0] r_rx_age, n_rx_age;
    logic [TIMER_WIDTH-1:0] r_change_age, n_change_age;
    logic [TIMER_WIDTH-1:0] r_press_age, n_press_age;
    logic r_link, n_link;
    logic r_shutdown, n_shutdown;
    logic r_supply, n_supply;
    logic r_btn_sample, n_btn_sample;
    logic r_btn_stable, n_btn_stable;
    logic r_long_done, n_long_done;
    logic r_wait_offline, n_wait_offline;
    logic r_run_offline, n_run_offline;

    // Result register.
    logic    r_out_valid;
    t_result r_out, n_out;

    logic advance;
    logic clicked;

    // A tick moves into the result register when that register is free or drains.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    // Saturating increment of a timer.
    function automatic logic [TIMER_WIDTH-1:0] age_inc(input logic [TIMER_WIDTH-1:0] a);
        age_inc = (a != TMAX) ? a + 1'b1 : TMAX;
    endfunction

    // Timer has reached a register value.
    function automatic logic reached(input logic [TIMER_WIDTH-1:0] a,
                                     input logic [CFG_W-1:0] lim);
        reached = CW'(a) >= CW'(lim);
    endfunction

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_delay      <= BOOT_DELAY_RST;
            r_ready_timeout   <= READY_TIMEOUT_RST;
            r_link_timeout    <= LINK_TIMEOUT_RST;
            r_shutdown_repeat <= SHUTDOWN_REPEAT_RST;
            r_debounce        <= DEBOUNCE_RST;
            r_long_press      <= LONG_PRESS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BOOT_DELAY:      r_boot_delay      <= i_cfg_data;
                REG_READY_TIMEOUT:   r_ready_timeout   <= i_cfg_data;
                REG_LINK_TIMEOUT:    r_link_timeout    <= i_cfg_data;
                REG_SHUTDOWN_REPEAT: r_shutdown_repeat <= i_cfg_data;
                REG_DEBOUNCE:        r_debounce        <= i_cfg_data;
                REG_LONG_PRESS:      r_long_press      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: valid flag and the tick's pin levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_button_raw  <= i_button_raw;
            r_poweroff_ok <= i_poweroff_ok;
            r_rx_frame    <= i_rx_frame;
            r_tx_ready    <= i_tx_ready;
        end
    end

    // One sequencer step: timers, link, debounce, long press, then phase logic.
    always_comb begin
        n_phase        = r_phase;
        n_phase_age    = age_inc(r_phase_age);
        n_repeat_age   = age_inc(r_repeat_age);
        n_rx_age       = age_inc(r_rx_age);
        n_change_age   = age_inc(r_change_age);
        n_press_age    = age_inc(r_press_age);
        n_link         = r_link;
        n_shutdown     = r_shutdown;
        n_supply       = r_supply;
        n_btn_sample   = r_btn_sample;
        n_btn_stable   = r_btn_stable;
        n_long_done    = r_long_done;
        n_wait_offline = r_wait_offline;
        n_run_offline  = r_run_offline;
        clicked        = 1'b0;
        n_out          = '0;

        // A received frame marks the link up in every phase.
        if (r_rx_frame) begin
            n_link   = 1'b1;
            n_rx_age = '0;
        end

        // Debounce: a level change restarts the hold timer.
        if (r_button_raw != r_btn_sample) begin
            n_btn_sample = r_button_raw;
            n_change_age = '0;
        end
        if (reached(n_change_age, r_debounce) && (n_btn_stable != n_btn_sample)) begin
            n_btn_stable = n_btn_sample;
            if (n_btn_stable) begin
                n_press_age = '0;
                n_long_done = 1'b0;
            end else if (!n_long_done) begin
                clicked = 1'b1;
            end
        end

        // Long press forces power off, once per press.
        if (n_btn_stable && !n_long_done && reached(n_press_age, r_long_press)) begin
            n_long_done            = 1'b1;
            n_supply               = 1'b0;
            n_link                 = 1'b0;
            n_shutdown             = 1'b0;
            n_out.forced_off_event = 1'b1;
            n_phase                = PH_FORCED;
            n_phase_age            = '0;
        end

        // Phase logic acts on the phase as updated by a forced power off.
        case (n_phase)
            PH_BOOT: begin
                n_supply = 1'b1;
                if (reached(n_phase_age, r_boot_delay)) begin
                    n_phase        = PH_WAIT;
                    n_phase_age    = '0;
                    n_wait_offline = 1'b0;
                    n_run_offline  = 1'b0;
                end
            end
            PH_WAIT: begin
                if (n_link) begin
                    n_phase       = PH_RUNNING;
                    n_phase_age   = '0;
                    n_run_offline = 1'b0;
                end else if (!n_wait_offline && reached(n_phase_age, r_ready_timeout)) begin
                    n_wait_offline = 1'b1;
                end
            end
            PH_RUNNING: begin
                if (n_link && reached(n_rx_age, r_link_timeout)) begin
                    n_link        = 1'b0;
                    n_run_offline = 1'b1;
                end else if (n_link && n_run_offline) begin
                    n_run_offline = 1'b0;
                end
                // A click starts a graceful shutdown with the first request due at once.
                if (clicked) begin
                    n_link                 = 1'b0;
                    n_shutdown             = 1'b1;
                    n_out.shutdown_started = 1'b1;
                    n_phase                = PH_SHUTDOWN;
                    n_phase_age            = '0;
                    if (CW'(r_shutdown_repeat) < CW'(TMAX)) begin
                        n_repeat_age = TIMER_WIDTH'(r_shutdown_repeat);
                    end else begin
                        n_repeat_age = TMAX;
                    end
                end
            end
            PH_SHUTDOWN: begin
                if (reached(n_repeat_age, r_shutdown_repeat) && r_tx_ready) begin
                    n_out.send_shutdown = 1'b1;
                    n_repeat_age        = '0;
                end
                if (r_poweroff_ok) begin
                    n_supply    = 1'b0;
                    n_link      = 1'b0;
                    n_shutdown  = 1'b0;
                    n_phase     = PH_OFF;
                    n_phase_age = '0;
                end
            end
            default: begin
                n_supply = 1'b0;
            end
        endcase

        // Result fields after the step.
        n_out.power_enable     = n_supply;
        n_out.failsafe         = (n_phase != PH_RUNNING);
        n_out.phase            = n_phase;
        n_out.link_up          = n_link;
        n_out.shutdown_pending = n_shutdown;
        if (n_phase == PH_WAIT) begin
            n_out.offline_shown = n_wait_offline;
        end else if (n_phase == PH_RUNNING) begin
            n_out.offline_shown = n_run_offline;
        end else begin
            n_out.offline_shown = 1'b0;
        end
    end

    // Sequencer state advances once per tick that moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_BOOT;
            r_phase_age    <= '0;
            r_repeat_age   <= '0;
            r_rx_age       <= '0;
            r_change_age   <= '0;
            r_press_age    <= '0;
            r_link         <= 1'b0;
            r_shutdown     <= 1'b0;
            r_supply       <= 1'b0;
            r_btn_sample   <= 1'b0;
            r_btn_stable   <= 1'b0;
            r_long_done    <= 1'b0;
            r_wait_offline <= 1'b0;
            r_run_offline  <= 1'b0;
        end else if (advance) begin
            r_phase        <= n_phase;
            r_phase_age    <= n_phase_age;
            r_repeat_age   <= n_repeat_age;
            r_rx_age       <= n_rx_age;
            r_change_age   <= n_change_age;
            r_press_age    <= n_press_age;
            r_link         <= n_link;
            r_shutdown     <= n_shutdown;
            r_supply       <= n_supply;
            r_btn_sample   <= n_btn_sample;
            r_btn_stable   <= n_btn_stable;
            r_long_done    <= n_long_done;
            r_wait_offline <= n_wait_offline;
            r_run_offline  <= n_run_offline;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_power_enable     = r_out.power_enable;
    assign o_failsafe         = r_out.failsafe;
    assign o_phase            = r_out.phase;
    assign o_link_up          = r_out.link_up;
    assign o_shutdown_pending = r_out.shutdown_pending;
    assign o_send_shutdown    = r_out.send_shutdown;
    assign o_offline_shown    = r_out.offline_shown;
    assign o_shutdown_started = r_out.shutdown_started;
    assign o_forced_off_event = r_out.forced_off_event;

endmodule
